// File: rtl/assert_macros.svh
// assertion macros used by first_fit_heap_allocator.sv
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// precondition implies the consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`endif
`endif

// File: rtl/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
// no dependencies
package ffha_pkg;

   // arena geometry
   localparam int ARENA_BYTES = 4096;
   localparam int OFF_W       = $clog2(ARENA_BYTES) + 1;
   localparam int IDX_W       = $clog2(ARENA_BYTES / 2);
   localparam int HDR_DEPTH   = ARENA_BYTES / 2;
   localparam int SUM_W       = 18;
   localparam int FIELD_W     = 12;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_SIZE = 2'd1,
      STATUS_NO_SPACE = 2'd2,
      STATUS_BAD_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic               cmd;
      logic [FIELD_W-1:0] req_size;
      logic [FIELD_W-1:0] user_addr;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] granted_addr;
      logic               merged;
   } rsp_type;

endpackage

// File: rtl/first_fit_heap_allocator.sv
// first-fit heap allocator: header walker, coalescer and header memory
// depends on ffha_pkg and assert_macros.svh
//
// One request is taken at a time; req_stall stays high until its result is
// in the output register. Every header visited takes a read issue and then
// a check on the registered read port of the header memory; an allocate
// walks the blocks before the fit, then writes the split header, if any,
// and the used header. When nothing fits, a coalesce pass walks every
// header (the header that ends a free run is read twice, and each free run
// is written back once) and a second fit pass follows. A free walks the
// headers up to and including the target. Every request then passes
// through ST_DONE, which loads the output register. Results wait in an
// output register, so a stalled result only holds the next request once
// that one is finished too. Header word 0 reads as one free block spanning
// the arena until first written; no clearing pass.
`include "assert_macros.svh"

module first_fit_heap_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffha_pkg::rsp_type rsp_data
);
   import ffha_pkg::*;

   localparam logic [SUM_W-1:0] ARENA_SUM  = SUM_W'(ARENA_BYTES);
   localparam logic [OFF_W-1:0] MAX_SIZE   = OFF_W'(ARENA_BYTES - 2);
   localparam logic [15:0]      HDR0_RESET = 16'(ARENA_BYTES - 2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIT_RD,
      ST_FIT_CHK,
      ST_SPLIT,
      ST_MARK,
      ST_CO_RD,
      ST_CO_CHK,
      ST_CO_NRD,
      ST_CO_NCHK,
      ST_CO_WR,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [OFF_W-1:0]   n_ff, n_in;
   logic [FIELD_W-1:0] target_ff, target_in;
   logic [15:0]        cur_sz_ff, cur_sz_in;
   logic               any_ff, any_in;
   logic               pass2_ff, pass2_in;
   status_type         res_status_ff, res_status_in;
   logic [FIELD_W-1:0] res_granted_ff, res_granted_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               hdr0_valid_ff, hdr0_valid_in;
   logic               rd_zero_ff, rd_zero_in;

   // header memory
   logic [15:0]        mem [HDR_DEPTH];
   logic [15:0]        rdata_ff;
   logic [IDX_W-1:0]   rd_idx;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [15:0]        wr_data;

   // decoded header and walk sums
   logic [15:0]        hdr;
   logic [15:0]        hsz;
   logic               hused;
   logic [SUM_W-1:0]   off_ext;
   logic [SUM_W-1:0]   end_sum;
   logic [SUM_W-1:0]   next_ext;
   logic [SUM_W-1:0]   next_end;
   logic               off_fits;
   logic [OFF_W-1:0]   split_off;

   assign hdr      = rd_zero_ff ? HDR0_RESET : rdata_ff;
   assign hsz      = {hdr[15:1], 1'b0};
   assign hused    = hdr[0];
   assign off_ext  = SUM_W'(off_ff);
   assign end_sum  = off_ext + SUM_W'(2) + SUM_W'(hsz);
   assign next_ext = off_ext + SUM_W'(2) + SUM_W'(cur_sz_ff);
   assign next_end = next_ext + SUM_W'(2) + SUM_W'(hsz);
   assign off_fits = (off_ext + SUM_W'(2)) <= ARENA_SUM;
   assign split_off = off_ff + OFF_W'(2) + n_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      off_in         = off_ff;
      n_in           = n_ff;
      target_in      = target_ff;
      cur_sz_in      = cur_sz_ff;
      any_in         = any_ff;
      pass2_in       = pass2_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rd_idx         = off_ff[IDX_W:1];
      wr_en          = 1'b0;
      wr_idx         = off_ff[IDX_W:1];
      wr_data        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in           = OFF_W'(req_data.req_size) + OFF_W'(req_data.req_size[0]);
               target_in      = req_data.user_addr - FIELD_W'(2);
               off_in         = '0;
               any_in         = 1'b0;
               pass2_in       = 1'b0;
               res_granted_in = '0;
               if (req_data.cmd == CMD_ALLOC) begin
                  if (req_data.req_size == '0 ||
                      OFF_W'(req_data.req_size) > MAX_SIZE) begin
                     res_status_in = STATUS_BAD_SIZE;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_FIT_RD;
                  end
               end else begin
                  if (req_data.user_addr < FIELD_W'(2) || req_data.user_addr[0]) begin
                     res_status_in = STATUS_BAD_FREE;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_FREE_RD;
                  end
               end
            end
         end

         // first-fit walk: issue read, then check the header
         ST_FIT_RD: begin
            if (!off_fits) begin
               off_in = '0;
               if (pass2_ff) begin
                  res_status_in = STATUS_NO_SPACE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_CO_RD;
               end
            end else begin
               state_in = ST_FIT_CHK;
            end
         end

         ST_FIT_CHK: begin
            if (end_sum > ARENA_SUM) begin
               off_in = '0;
               if (pass2_ff) begin
                  res_status_in = STATUS_NO_SPACE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_CO_RD;
               end
            end else if (!hused && hsz >= 16'(n_ff)) begin
               cur_sz_in = hsz;
               state_in  = ST_SPLIT;
            end else begin
               off_in   = OFF_W'(end_sum);
               state_in = ST_FIT_RD;
            end
         end

         // remainder header after the granted payload
         ST_SPLIT: begin
            if (cur_sz_ff > 16'(n_ff)) begin
               wr_en   = 1'b1;
               wr_idx  = split_off[IDX_W:1];
               wr_data = cur_sz_ff - 16'(n_ff) - 16'd2;
            end
            state_in = ST_MARK;
         end

         // mark the granted block used
         ST_MARK: begin
            wr_en          = 1'b1;
            wr_data        = 16'(n_ff) | 16'd1;
            res_status_in  = STATUS_OK;
            res_granted_in = FIELD_W'(off_ff + OFF_W'(2));
            state_in       = ST_DONE;
         end

         // coalesce pass: look at the block at off
         ST_CO_RD: begin
            if (!off_fits) begin
               off_in   = '0;
               pass2_in = 1'b1;
               state_in = ST_FIT_RD;
            end else begin
               state_in = ST_CO_CHK;
            end
         end

         ST_CO_CHK: begin
            if (end_sum > ARENA_SUM) begin
               off_in   = '0;
               pass2_in = 1'b1;
               state_in = ST_FIT_RD;
            end else if (hused) begin
               off_in   = OFF_W'(end_sum);
               state_in = ST_CO_RD;
            end else begin
               cur_sz_in = hsz;
               state_in  = ST_CO_NRD;
            end
         end

         // read the neighbor that follows the free run
         ST_CO_NRD: begin
            if (next_ext + SUM_W'(2) > ARENA_SUM) begin
               state_in = ST_CO_WR;
            end else begin
               rd_idx   = next_ext[IDX_W:1];
               state_in = ST_CO_NCHK;
            end
         end

         ST_CO_NCHK: begin
            if (hused || next_end > ARENA_SUM) begin
               state_in = ST_CO_WR;
            end else begin
               cur_sz_in = cur_sz_ff + 16'd2 + hsz;
               any_in    = 1'b1;
               state_in  = ST_CO_NRD;
            end
         end

         // write back the merged run and step past it
         ST_CO_WR: begin
            wr_en    = 1'b1;
            wr_data  = cur_sz_ff;
            off_in   = OFF_W'(next_ext);
            state_in = ST_CO_RD;
         end

         // free walk toward the target header
         ST_FREE_RD: begin
            if (!off_fits) begin
               res_status_in = STATUS_BAD_FREE;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_FREE_CHK;
            end
         end

         ST_FREE_CHK: begin
            if (off_ff == OFF_W'(target_ff)) begin
               if (hused) begin
                  wr_en         = 1'b1;
                  wr_data       = hsz;
                  res_status_in = STATUS_OK;
               end else begin
                  res_status_in = STATUS_BAD_FREE;
               end
               state_in = ST_DONE;
            end else if (off_ff > OFF_W'(target_ff) || end_sum > ARENA_SUM) begin
               res_status_in = STATUS_BAD_FREE;
               state_in      = ST_DONE;
            end else begin
               off_in   = OFF_W'(end_sum);
               state_in = ST_FREE_RD;
            end
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = res_status_ff;
               rsp_data_in.granted_addr = res_granted_ff;
               rsp_data_in.merged       = any_ff;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // word 0 valid bit and zero-read tracking
   assign hdr0_valid_in = hdr0_valid_ff | (wr_en && wr_idx == '0);
   assign rd_zero_in    = (rd_idx == '0) && !hdr0_valid_ff;

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         hdr0_valid_ff <= 1'b0;
         rd_zero_ff    <= 1'b0;
         any_ff        <= 1'b0;
         pass2_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         hdr0_valid_ff <= hdr0_valid_in;
         rd_zero_ff    <= rd_zero_in;
         any_ff        <= any_in;
         pass2_ff      <= pass2_in;
      end
      off_ff         <= off_in;
      n_ff           <= n_in;
      target_ff      <= target_in;
      cur_sz_ff      <= cur_sz_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // header memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rdata_ff <= mem[rd_idx];
   end

   // checks
   `ASSERT_IMPLIES(a_no_write_idle, clock, reset, state_ff == ST_IDLE || state_ff == ST_DONE, !wr_en, "header write outside a walk")
   `ASSERT_IMPLIES(a_chk_in_arena, clock, reset, state_ff == ST_FIT_CHK || state_ff == ST_CO_CHK || state_ff == ST_FREE_CHK, (off_ext + SUM_W'(2)) <= ARENA_SUM, "header check beyond arena end")
   `ASSERT_IMPLIES(a_grant_even, clock, reset, rsp_valid_ff, !rsp_data_ff.granted_addr[0], "granted address is odd")
   `ASSERT_IMPLIES(a_merge_alloc, clock, reset, rsp_valid_ff && rsp_data_ff.merged, rsp_data_ff.status == STATUS_OK || rsp_data_ff.status == STATUS_NO_SPACE, "merge reported with a bad status")

endmodule
